[rtl/bfa_pkg.sv]
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared widths, operation and status codes, register map and types of the
// bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

	localparam int FRAME_BITS     = 20;
	localparam int COUNT_BITS     = 16;
	localparam int DEF_MAX_FRAMES = 32768;
	// byte index reachable with a 16-bit frame offset
	localparam int BIDX_BITS      = COUNT_BITS - 3;

	// operations
	localparam logic [1:0] OP_INIT  = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_MARK  = 2'd2;

	// result status
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_FREE  = 3'd1;
	localparam logic [2:0] ST_RANGE    = 3'd2;
	localparam logic [2:0] ST_USED     = 3'd3;
	localparam logic [2:0] ST_BAD_SIZE = 3'd4;

	// register map, register index = paddr[3:2]
	localparam int         ADDR_BITS      = 4;
	localparam logic [1:0] REG_POOL_BASE  = 2'd0;
	localparam logic [1:0] REG_POOL_COUNT = 2'd1;
	localparam logic [1:0] REG_INFO_FRAME = 2'd2;

	// bitmap byte patterns, MSB is the lowest frame of the byte
	localparam logic [7:0] BYTE_ALL_FREE   = 8'hFF;
	localparam logic [7:0] BYTE_FIRST_RSVD = 8'h7F;
	localparam logic [7:0] BIT_MSB         = 8'h80;

	typedef struct packed {
		logic [FRAME_BITS-1:0] pool_base;
		logic [COUNT_BITS-1:0] pool_count;
		logic [FRAME_BITS-1:0] info_frame;
	} cfg_t;

	typedef struct packed {
		logic                 we;
		logic [BIDX_BITS-1:0] waddr;
		logic [7:0]           wdata;
		logic [BIDX_BITS-1:0] raddr;
	} mem_req_t;

endpackage

[rtl/bfa_if.sv]
// ----------------------------------------------------------------------------
// bfa_if
// Request and response channels of the bitmap frame allocator.
// ----------------------------------------------------------------------------
interface bfa_req_if import bfa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [1:0]            operation;
	logic [FRAME_BITS-1:0] range_start;
	logic [COUNT_BITS-1:0] range_count;

	modport source(output valid, operation, range_start, range_count, input ready);
	modport sink(input valid, operation, range_start, range_count, output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [FRAME_BITS-1:0] frame_number;
	logic [2:0]            status;
	logic [COUNT_BITS-1:0] free_frames;

	modport source(output valid, frame_number, status, free_frames, input ready);
	modport sink(input valid, frame_number, status, free_frames, output ready);
endinterface

[rtl/bfa_ram.sv]
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/bfa_cfg.sv]
// ----------------------------------------------------------------------------
// bfa_cfg
// APB register block: pool base, pool frame count and info frame number.
// ----------------------------------------------------------------------------
module bfa_cfg import bfa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	logic [1:0] reg_idx;
	logic       wr_en;
	cfg_t       cfg_q;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_POOL_BASE:  cfg_q.pool_base  <= pwdata[FRAME_BITS-1:0];
				REG_POOL_COUNT: cfg_q.pool_count <= pwdata[COUNT_BITS-1:0];
				REG_INFO_FRAME: cfg_q.info_frame <= pwdata[FRAME_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_POOL_BASE:  prdata = 32'(cfg_q.pool_base);
			REG_POOL_COUNT: prdata = 32'(cfg_q.pool_count);
			REG_INFO_FRAME: prdata = 32'(cfg_q.info_frame);
			default:        prdata = '0;
		endcase
	end

endmodule

[rtl/bfa_ctrl.sv]
// ----------------------------------------------------------------------------
// bfa_ctrl
// Operation sequencer: init sweep writing the bitmap RAM, first-fit byte scan
// and per-frame range marking as read-modify-write on it, plus the free
// counter and the result register.
// ----------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*; #(
	parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	bfa_req_if.sink         req,
	bfa_rsp_if.source       rsp,
	output mem_req_t        mem_req,
	input  logic [7:0]      mem_rdata
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_INIT   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_MK_CHK = 3'd3;
	localparam logic [2:0] S_MK_WR  = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	// leading set bit, 0 is the MSB
	function automatic logic [2:0] first_set(input logic [7:0] b);
		logic [2:0] pos;
		pos = '0;
		for (int j = 0; j < 8; j++) begin
			if (b[j]) begin
				pos = 3'(7 - j);
			end
		end
		return pos;
	endfunction

	logic [2:0]            state_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [BIDX_BITS:0]    idx_q;
	logic [BIDX_BITS:0]    nbytes_q;
	logic [COUNT_BITS-1:0] n_q;
	logic [COUNT_BITS-1:0] k_q;
	logic [COUNT_BITS-1:0] kcount_q;
	logic [FRAME_BITS:0]   f_q;
	logic [FRAME_BITS:0]   hi_q;
	logic                  rv_s1;
	logic [BIDX_BITS-1:0]  ridx_s1;
	logic [2:0]            res_status_q;
	logic [FRAME_BITS-1:0] res_frame_q;
	logic                  ov_q;
	logic [FRAME_BITS-1:0] oframe_q;
	logic [2:0]            ostatus_q;
	logic [COUNT_BITS-1:0] ofree_q;

	logic                  accept_c;
	logic                  out_load_c;
	logic [COUNT_BITS-1:0] n_c;
	logic                  bad_size_c;
	logic                  rsvd_c;
	logic                  iss_c;
	logic                  last_c;
	logic [7:0]            tail_mask_c;
	logic [7:0]            masked_c;
	logic [2:0]            pos_c;
	logic                  found_c;
	logic [FRAME_BITS:0]   base_c;
	logic [FRAME_BITS:0]   off_c;
	logic [COUNT_BITS-1:0] off16_c;
	logic                  in_rng_c;
	logic [7:0]            bitm_c;
	logic                  bit_free_c;

	assign req.ready        = (state_q == S_IDLE);
	assign accept_c         = req.valid && req.ready;
	assign out_load_c       = (state_q == S_DONE) && (!ov_q || rsp.ready);
	assign rsp.valid        = ov_q;
	assign rsp.frame_number = oframe_q;
	assign rsp.status       = ostatus_q;
	assign rsp.free_frames  = ofree_q;

	// pool size clipped to capacity
	assign n_c = (32'(cfg.pool_count) > MAX_FRAMES) ? COUNT_BITS'(MAX_FRAMES)
	                                                : cfg.pool_count;
	assign bad_size_c = (cfg.pool_count[2:0] != 3'd0) ||
	                    (32'(cfg.pool_count) > MAX_FRAMES);
	assign rsvd_c     = (cfg.info_frame == '0);

	// scan: issue one byte read a cycle, check the byte that returns
	assign iss_c       = (idx_q < nbytes_q);
	assign last_c      = (({1'b0, ridx_s1} + 1'b1) == nbytes_q);
	assign tail_mask_c = (last_c && (n_q[2:0] != 3'd0)) ? ~(BYTE_ALL_FREE >> n_q[2:0])
	                                                    : BYTE_ALL_FREE;
	assign masked_c    = mem_rdata & tail_mask_c;
	assign pos_c       = first_set(masked_c);
	assign found_c     = rv_s1 && (masked_c != 8'd0);

	// mark: current frame relative to the pool
	assign base_c     = {1'b0, cfg.pool_base};
	assign off_c      = f_q - base_c;
	assign off16_c    = off_c[COUNT_BITS-1:0];
	assign in_rng_c   = (f_q >= base_c) && (f_q < hi_q);
	assign bitm_c     = BIT_MSB >> off16_c[2:0];
	assign bit_free_c = ((mem_rdata & bitm_c) != 8'd0);

	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = off16_c[COUNT_BITS-1:3];
		mem_req.wdata = mem_rdata & ~bitm_c;
		mem_req.raddr = (state_q == S_SCAN) ? idx_q[BIDX_BITS-1:0]
		                                    : off16_c[COUNT_BITS-1:3];
		case (state_q)
			S_INIT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = idx_q[BIDX_BITS-1:0];
				mem_req.wdata = (idx_q == '0 && rsvd_c) ? BYTE_FIRST_RSVD : BYTE_ALL_FREE;
			end
			S_SCAN: begin
				mem_req.we    = found_c;
				mem_req.waddr = ridx_s1;
				mem_req.wdata = mem_rdata & ~(BIT_MSB >> pos_c);
			end
			S_MK_WR: begin
				mem_req.we = bit_free_c;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			rv_s1   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (out_load_c) begin
				ov_q      <= 1'b1;
				oframe_q  <= res_frame_q;
				ostatus_q <= res_status_q;
				ofree_q   <= cnt_q;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					rv_s1 <= 1'b0;
					if (accept_c) begin
						res_frame_q  <= '0;
						res_status_q <= ST_OK;
						idx_q        <= '0;
						case (req.operation)
							OP_INIT: begin
								nbytes_q <= {1'b0, cfg.pool_count[COUNT_BITS-1:3]};
								if (bad_size_c) begin
									res_status_q <= ST_BAD_SIZE;
									state_q      <= S_DONE;
								end else if (cfg.pool_count == '0) begin
									cnt_q   <= '0;
									state_q <= S_DONE;
								end else begin
									cnt_q   <= cfg.pool_count - COUNT_BITS'(rsvd_c);
									state_q <= S_INIT;
								end
							end
							OP_ALLOC: begin
								n_q      <= n_c;
								nbytes_q <= (BIDX_BITS+1)'(({1'b0, n_c} + 17'd7) >> 3);
								if (cnt_q == '0 || n_c == '0) begin
									res_status_q <= ST_NO_FREE;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_MARK: begin
								k_q      <= '0;
								kcount_q <= req.range_count;
								f_q      <= {1'b0, req.range_start};
								hi_q     <= base_c + (FRAME_BITS+1)'(n_c);
								state_q  <= S_MK_CHK;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end

				S_INIT: begin
					idx_q <= idx_q + 1'b1;
					if ((idx_q + 1'b1) == nbytes_q) begin
						state_q <= S_DONE;
					end
				end

				S_SCAN: begin
					rv_s1   <= iss_c;
					ridx_s1 <= idx_q[BIDX_BITS-1:0];
					idx_q   <= idx_q + (BIDX_BITS+1)'(iss_c);
					if (found_c) begin
						// drop the read still in flight
						rv_s1       <= 1'b0;
						cnt_q       <= cnt_q - 1'b1;
						res_frame_q <= cfg.pool_base + FRAME_BITS'({ridx_s1, pos_c});
						state_q     <= S_DONE;
					end else if (rv_s1 && last_c) begin
						rv_s1        <= 1'b0;
						res_status_q <= ST_NO_FREE;
						state_q      <= S_DONE;
					end
				end

				S_MK_CHK: begin
					if (k_q == kcount_q) begin
						state_q <= S_DONE;
					end else if (!in_rng_c) begin
						res_status_q <= ST_RANGE;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_MK_WR;
					end
				end

				S_MK_WR: begin
					if (!bit_free_c) begin
						res_status_q <= ST_USED;
						state_q      <= S_DONE;
					end else begin
						if (cnt_q != '0) begin
							cnt_q <= cnt_q - 1'b1;
						end
						k_q     <= k_q + 1'b1;
						f_q     <= f_q + 1'b1;
						state_q <= S_MK_CHK;
					end
				end

				S_DONE: begin
					if (out_load_c) begin
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/bitmap_frame_allocator_top.sv]
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// First-fit page frame allocator over a byte-wide free bitmap in RAM.
//
// Request channel (req): operation, range_start, range_count; one word is
// taken per operation, and ready is high only while no operation is running.
// Response channel (rsp): one word per request with frame_number, status
// and free_frames, held in an output register until taken.
// Registers sit on the APB port: pool base, pool frame count, info frame.
// Write them only while no operation is in flight.
// Steps per operation on the bitmap RAM:
//   init      the pool's bytes written in turn (one byte written a cycle)
//   allocate  bytes scanned up to the first free frame (one byte read
//             a cycle, pipelined against the registered RAM read)
//   mark      per frame marked: read, then check and write back;
//             it stops on a frame already used
//   bad size, no free counter, unknown op: answered with no RAM access
// The next request is taken while the previous response still waits, but
// its response is held back until the output register frees up.
// Reset clears the registers and the free counter; the bitmap holds no
// defined content until the first init.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top import bfa_pkg::*; #(
	parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	bfa_req_if.sink              req,
	bfa_rsp_if.source            rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int DEPTH = (MAX_FRAMES + 7) / 8;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cfg_t       cfg;
	mem_req_t   mem_req;
	logic [7:0] mem_rdata;

	bfa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bfa_ctrl #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req),
		.rsp       (rsp),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	bfa_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_bitmap (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (AW'(mem_req.waddr)),
		.wdata (mem_req.wdata),
		.raddr (AW'(mem_req.raddr)),
		.rdata (mem_rdata)
	);

	// one operation at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while an operation was starting");

	// bitmap is only written by a running operation
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> !req.ready)
		else $error("bitmap written while idle");

	// a frame number comes only with a successful allocation
	a_frame_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status != ST_OK) |-> (rsp.frame_number == '0))
		else $error("frame number set on a failed operation");

endmodule

[sim/tb_bitmap_frame_allocator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_frame_allocator_top
// Drives init, allocate and mark-range requests into the frame allocator and
// keeps its own copy of the free bitmap, free counter and pool registers.
// Each response word is checked field by field against the oldest outstanding
// prediction. Directed cases come first, then random pool sessions under
// several idling patterns, with one long response hold-off.
// ----------------------------------------------------------------------------
module tb_bitmap_frame_allocator_top;
	import bfa_pkg::*;

	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam int         MAP_BYTES    = DEF_MAX_FRAMES / 8;
	localparam int         RANDOM_ITEMS = 1300;
	localparam int         SETTLE_CYCLES = 4;
	localparam longint     RUN_LIMIT_NS = 64'd60_000_000;

	typedef struct packed {
		logic [FRAME_BITS-1:0] frame_number;
		logic [2:0]            status;
		logic [COUNT_BITS-1:0] free_frames;
	} alloc_rsp_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	bfa_req_if req_if();
	bfa_rsp_if rsp_if();

	bitmap_frame_allocator_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.rsp     (rsp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the allocator
	logic [FRAME_BITS-1:0] pool_base;
	logic [COUNT_BITS-1:0] pool_count;
	logic [FRAME_BITS-1:0] info_frame;
	logic [7:0]            free_map [MAP_BYTES];
	logic [COUNT_BITS-1:0] free_count;
	int                    map_bytes_written;

	alloc_rsp_t pending_rsp_q [$];
	int         rsp_errors;
	int         req_idle_pct;
	int         rsp_stall_pct;
	logic       rsp_hold;
	int         hold_len;
	event       hold_go;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int pool_frames();
		return (pool_count > DEF_MAX_FRAMES) ? DEF_MAX_FRAMES : int'(pool_count);
	endfunction

	// true when every bitmap byte the pool spans has been written by an init
	function automatic bit map_covers_pool();
		return ((pool_frames() + 7) / 8) <= map_bytes_written;
	endfunction

	function automatic alloc_rsp_t allocator_outcome(input logic [1:0] op,
			input logic [FRAME_BITS-1:0] start, input logic [COUNT_BITS-1:0] cnt);
		alloc_rsp_t r;
		int         n;
		int         off;
		int         k;
		longint     f;
		r = '0;
		r.status = ST_OK;
		n = pool_frames();
		case (op)
			OP_INIT: begin
				if (pool_count[2:0] != 3'd0 || pool_count > DEF_MAX_FRAMES) begin
					r.status = ST_BAD_SIZE;
				end else begin
					for (k = 0; k < int'(pool_count) / 8; k++)
						free_map[k] = BYTE_ALL_FREE;
					free_count = pool_count;
					if (info_frame == '0 && pool_count != '0) begin
						free_map[0] = BYTE_FIRST_RSVD;
						free_count--;
					end
					if (int'(pool_count) / 8 > map_bytes_written)
						map_bytes_written = int'(pool_count) / 8;
				end
			end
			OP_ALLOC: begin
				r.status = ST_NO_FREE;
				if (free_count != '0) begin
					for (off = 0; off < n; off++) begin
						if (free_map[off >> 3][7 - (off & 7)]) begin
							free_map[off >> 3][7 - (off & 7)] = 1'b0;
							free_count--;
							r.frame_number = FRAME_BITS'(pool_base + off);
							r.status = ST_OK;
							break;
						end
					end
				end
			end
			OP_MARK: begin
				// frame numbers compared without wrap
				for (k = 0; k < int'(cnt); k++) begin
					f = longint'(start) + k;
					if (f < longint'(pool_base) || f >= longint'(pool_base) + n) begin
						r.status = ST_RANGE;
						break;
					end
					off = int'(f - longint'(pool_base));
					if (!free_map[off >> 3][7 - (off & 7)]) begin
						r.status = ST_USED;
						break;
					end
					free_map[off >> 3][7 - (off & 7)] = 1'b0;
					if (free_count != '0)
						free_count--;
				end
			end
			default: begin
			end
		endcase
		r.free_frames = free_count;
		return r;
	endfunction

	// response side: check each word taken, then decide next cycle's ready
	always @(posedge clk) begin
		alloc_rsp_t want;
		if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (pending_rsp_q.size() == 0) begin
				$error("response word with none outstanding: frame_number %0h status %0d free_frames %0d",
					rsp_if.frame_number, rsp_if.status, rsp_if.free_frames);
				rsp_errors++;
			end else begin
				want = pending_rsp_q.pop_front();
				if (rsp_if.frame_number !== want.frame_number) begin
					$error("frame_number: expected %0h, got %0h", want.frame_number,
						rsp_if.frame_number);
					rsp_errors++;
				end
				if (rsp_if.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_if.status);
					rsp_errors++;
				end
				if (rsp_if.free_frames !== want.free_frames) begin
					$error("free_frames: expected %0d, got %0d", want.free_frames,
						rsp_if.free_frames);
					rsp_errors++;
				end
			end
		end
		rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
	end

	// long response hold-off, counted here so the sender can keep offering
	initial begin
		rsp_hold = 1'b0;
		forever begin
			@(hold_go);
			rsp_hold <= 1'b1;
			repeat (hold_len) @(posedge clk);
			rsp_hold <= 1'b0;
		end
	end

	task automatic send_word(input logic [1:0] op, input logic [FRAME_BITS-1:0] start,
			input logic [COUNT_BITS-1:0] cnt);
		if ($urandom_range(99) < req_idle_pct) begin
			req_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < req_idle_pct);
		end
		req_if.valid       <= 1'b1;
		req_if.operation   <= op;
		req_if.range_start <= start;
		req_if.range_count <= cnt;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		pending_rsp_q.push_back(allocator_outcome(op, start, cnt));
	endtask

	// drop valid and hold until every outstanding response has come back
	task automatic wait_drained();
		req_if.valid <= 1'b0;
		while (pending_rsp_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		wait_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_POOL_BASE:  pool_base  = value[FRAME_BITS-1:0];
			REG_POOL_COUNT: pool_count = value[COUNT_BITS-1:0];
			REG_INFO_FRAME: info_frame = value[FRAME_BITS-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic set_pool(input logic [FRAME_BITS-1:0] base,
			input logic [COUNT_BITS-1:0] count, input logic [FRAME_BITS-1:0] info);
		write_reg(REG_POOL_BASE, 32'(base));
		write_reg(REG_POOL_COUNT, 32'(count));
		write_reg(REG_INFO_FRAME, 32'(info));
	endtask

	function automatic logic [COUNT_BITS-1:0] pick_pool_count();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 70)
			return COUNT_BITS'(8 * $urandom_range(32, 1));
		if (r < 80)
			return COUNT_BITS'($urandom_range(255, 1));
		if (r < 88)
			return COUNT_BITS'(8 * $urandom_range(512, 33));
		if (r < 93)
			return COUNT_BITS'(DEF_MAX_FRAMES);
		return COUNT_BITS'($urandom);
	endfunction

	// random request, kept clear of bitmap bytes no init has written
	task automatic pick_word(output logic [1:0] op, output logic [FRAME_BITS-1:0] start,
			output logic [COUNT_BITS-1:0] cnt);
		int r;
		int n;
		int lim;
		n = pool_frames();
		r = $urandom_range(99);
		start = FRAME_BITS'($urandom);
		cnt   = COUNT_BITS'($urandom);
		if (r < 45)
			op = OP_ALLOC;
		else if (r < 85)
			op = OP_MARK;
		else if (r < 93)
			op = OP_INIT;
		else
			op = OP_UNUSED;
		if (op == OP_MARK) begin
			if ($urandom_range(9) != 0)
				start = FRAME_BITS'(int'(pool_base) + $urandom_range(n + 8) - 4);
			r = $urandom_range(99);
			lim = (n > 256) ? 64 : n + 8;
			if (r < 65)
				cnt = COUNT_BITS'($urandom_range(12));
			else if (r < 85)
				cnt = COUNT_BITS'($urandom_range(lim));
			else if (n > 256)
				cnt = COUNT_BITS'($urandom_range(12));
		end
		if (!map_covers_pool()) begin
			if (op == OP_ALLOC && free_count != '0)
				op = OP_UNUSED;
			if (op == OP_MARK)
				start = (pool_base != '0) ? pool_base - 1'b1 : FRAME_BITS'(n);
		end
	endtask

	task automatic test_after_reset();
		send_word(OP_ALLOC, '0, '0);
		send_word(OP_MARK, '0, '0);
		send_word(OP_MARK, '0, 16'd1);
		send_word(OP_UNUSED, '1, '1);
		send_word(OP_INIT, '0, '0);
	endtask

	task automatic test_small_pool();
		logic [FRAME_BITS-1:0] base;
		base = 20'h12340;
		set_pool(base, 16'd8, '0);
		send_word(OP_INIT, '1, '1);
		send_word(OP_ALLOC, '0, '0);
		send_word(OP_MARK, base + 20'd3, 16'd2);
		send_word(OP_MARK, base + 20'd3, 16'd1);
		// runs off the pool end after marking two frames
		send_word(OP_MARK, base + 20'd6, 16'd5);
		send_word(OP_ALLOC, '0, '0);
		send_word(OP_ALLOC, '0, '0);
		send_word(OP_ALLOC, '0, '0);
	endtask

	task automatic test_bad_size();
		write_reg(REG_POOL_COUNT, 32'd12);
		send_word(OP_INIT, '0, '0);
		write_reg(REG_POOL_COUNT, 32'hFFFF);
		send_word(OP_INIT, '0, '0);
	endtask

	task automatic test_counter_limits();
		set_pool('0, 16'd16, 20'hFFFFF);
		send_word(OP_INIT, '0, '0);
		write_reg(REG_POOL_COUNT, 32'd8);
		send_word(OP_INIT, '0, '0);
		// more free bits than the counter holds: counter floors at zero
		write_reg(REG_POOL_COUNT, 32'd16);
		send_word(OP_MARK, '0, 16'd16);
		send_word(OP_ALLOC, '0, '0);
		send_word(OP_INIT, '0, '0);
		// counter left non-zero with no free bit inside the pool
		write_reg(REG_POOL_COUNT, 32'd8);
		send_word(OP_MARK, '0, 16'd8);
		send_word(OP_ALLOC, '0, '0);
	endtask

	task automatic test_wrap_and_full_pool();
		set_pool(20'hFFFFE, 16'd8, '0);
		send_word(OP_INIT, '0, '0);
		send_word(OP_ALLOC, '0, '0);
		send_word(OP_ALLOC, '0, '0);
		set_pool(20'hF8000, 16'h8000, 20'hFFFFF);
		send_word(OP_INIT, '0, '0);
		send_word(OP_MARK, 20'hF8000, 16'h8000);
		send_word(OP_ALLOC, '0, '0);
	endtask

	task automatic test_backpressure();
		logic [1:0]            op;
		logic [FRAME_BITS-1:0] start;
		logic [COUNT_BITS-1:0] cnt;
		int                    k;
		set_pool(FRAME_BITS'($urandom), 16'd64, '0);
		send_word(OP_INIT, '0, '0);
		hold_len = 400;
		-> hold_go;
		for (k = 0; k < 12; k++) begin
			pick_word(op, start, cnt);
			send_word(op, start, cnt);
		end
		// pause until the last response is back, then resume
		wait_drained();
		for (k = 0; k < 8; k++) begin
			pick_word(op, start, cnt);
			send_word(op, start, cnt);
		end
	endtask

	task automatic test_random();
		logic [1:0]            op;
		logic [FRAME_BITS-1:0] start;
		logic [COUNT_BITS-1:0] cnt;
		logic [FRAME_BITS-1:0] base;
		logic [FRAME_BITS-1:0] info;
		int                    session;
		int                    len;
		int                    k;
		int                    taken;
		int                    r;
		session = 0;
		taken = 0;
		while (taken < RANDOM_ITEMS) begin
			wait_drained();
			case (session % 4)
				0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
				1: begin req_idle_pct = 60; rsp_stall_pct = 0;  end
				2: begin req_idle_pct = 0;  rsp_stall_pct = 60; end
				default: begin req_idle_pct = 37; rsp_stall_pct = 37; end
			endcase
			r = $urandom_range(9);
			base = (r == 0) ? '0 : (r == 1) ? '1 : FRAME_BITS'($urandom);
			r = $urandom_range(19);
			info = (r < 10) ? '0 : (r == 10) ? '1 : FRAME_BITS'($urandom);
			set_pool(base, pick_pool_count(), info);
			send_word(OP_INIT, FRAME_BITS'($urandom), COUNT_BITS'($urandom));
			taken++;
			len = $urandom_range(40, 24);
			for (k = 0; k < len; k++) begin
				if (k == len / 2 && $urandom_range(4) == 0)
					write_reg(REG_POOL_COUNT, 32'(pick_pool_count()));
				pick_word(op, start, cnt);
				send_word(op, start, cnt);
				if (op != OP_UNUSED)
					taken++;
			end
			session++;
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		req_if.valid          = 1'b0;
		req_if.operation      = OP_INIT;
		req_if.range_start    = '0;
		req_if.range_count    = '0;
		rsp_if.ready          = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		pool_base             = '0;
		pool_count            = '0;
		info_frame            = '0;
		free_count            = '0;
		map_bytes_written     = 0;
		rsp_errors            = 0;
		req_idle_pct          = 0;
		rsp_stall_pct         = 0;
		hold_len              = 0;
		foreach (free_map[i])
			free_map[i] = 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_small_pool();
		test_bad_size();
		test_counter_limits();
		test_wrap_and_full_pool();
		test_backpressure();
		test_random();

		wait_drained();
		repeat (20) @(posedge clk);
		if (rsp_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/bfa_pkg.sv
rtl/bfa_if.sv
rtl/bfa_ram.sv
rtl/bfa_cfg.sv
rtl/bfa_ctrl.sv
rtl/bitmap_frame_allocator_top.sv
sim/tb_bitmap_frame_allocator_top.sv
